// ===== hw/rtl/efr_pkg.sv =====
package efr_pkg;

  localparam int DEF_MACHINES     = 32;
  localparam int DEF_JOBS         = 32;
  localparam int DEF_HORIZON      = 8192;
  localparam int DEF_MAX_DURATION = 63;

  localparam int SAT_MAX   = 8191;
  localparam int WORD_BITS = 64;
  localparam int OFF_BITS  = 6;
  localparam int LEN_BITS  = 7;

  // result of one pass of the word unit over a 64-slot occupancy word
  typedef struct packed {
    logic                 hit;    // a busy slot lies inside the window
    logic                 last;   // window reaches the end of the request
    logic [OFF_BITS-1:0]  f_off;  // first busy slot, relative to the offset
    logic [LEN_BITS-1:0]  span;   // slots from the offset to the word end
    logic [WORD_BITS-1:0] mask;   // window bits inside the word
  } fit_t;

endpackage

// ===== hw/rtl/earliest_fit_timeline_reserver_unit.sv =====
// channel  signals                             beat accepted when
// -------  ----------------------------------  ------------------------
// in       job_id, machine_id, duration        in_valid  && in_ready
// out      start_time, end_time, makespan,     out_valid && out_ready
//          overflow
//
// After reset the occupancy RAM is zeroed one word per cycle, all
// MACHINES*HORIZON/64 words (4096 by default), with in_ready low.
// Per beat: setup, a scan of each 64-slot word (restarting past each blocked
// candidate start), a pass over the words touched to mark the slots, a post.
// One beat in flight; a held result only delays posting the next one.
module earliest_fit_timeline_reserver_unit #(
  parameter int MACHINES     = efr_pkg::DEF_MACHINES,
  parameter int JOBS         = efr_pkg::DEF_JOBS,
  parameter int HORIZON      = efr_pkg::DEF_HORIZON,
  parameter int MAX_DURATION = efr_pkg::DEF_MAX_DURATION
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  job_id,
  input  logic [4:0]  machine_id,
  input  logic [5:0]  duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] start_time,
  output logic [12:0] end_time,
  output logic [12:0] makespan,
  output logic        overflow
);

  localparam int WB        = efr_pkg::WORD_BITS;
  localparam int OB        = efr_pkg::OFF_BITS;
  localparam int MAP_WORDS = (MACHINES * HORIZON + WB - 1) / WB;
  localparam int MW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int AW        = $clog2(MACHINES * HORIZON + WB);
  localparam int TW        = $clog2(HORIZON + MAX_DURATION + 1);
  localparam int JW        = JOBS > 1 ? $clog2(JOBS) : 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_EVAL  = 8'b0001_0000,
    S_WRD   = 8'b0010_0000,
    S_WMOD  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t            state;
  logic [4:0]        mach_q;
  logic [5:0]        dur_q;
  logic [TW-1:0]     s;
  logic [TW-1:0]     p;
  logic [AW-1:0]     a;
  logic [AW-1:0]     a_s;
  logic              ovf_q;
  logic [MW-1:0]     clr_cnt;
  logic [JOBS-1:0]   rdy_valid;
  logic [12:0]       latest_end;

  logic              map_we;
  logic [MW-1:0]     map_waddr;
  logic [WB-1:0]     map_wdata;
  logic [MW-1:0]     map_raddr;
  logic [WB-1:0]     map_rdata;
  logic              rdy_we;
  logic [JW-1:0]     rdy_addr_q;
  logic [12:0]       rdy_rdata;

  efr_pkg::fit_t     fit;
  logic [TW:0]       need;
  logic [TW:0]       rem_full;
  logic [TW-1:0]     p_adv;
  logic [AW-1:0]     a_adv;
  logic [TW-1:0]     p_hit;
  logic [AW-1:0]     a_hit;
  logic [TW-1:0]     rdy_cur;
  logic [12:0]       start_sat;
  logic [12:0]       end_sat;
  logic [12:0]       le_new;
  logic              bad_req;
  logic              post;

  function automatic logic [MW-1:0] word_of(input logic [AW-1:0] x);
    return MW'(x >> OB);
  endfunction

  efr_ram #(.WIDTH(WB), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  efr_ram #(.WIDTH(13), .DEPTH(JOBS)) u_ready (
    .clk   (clk),
    .we    (rdy_we),
    .waddr (rdy_addr_q),
    .wdata (end_sat),
    .raddr (JW'(job_id)),
    .rdata (rdy_rdata)
  );

  efr_word_unit u_unit (
    .word (map_rdata),
    .off  (a[OB-1:0]),
    .rem  (efr_pkg::LEN_BITS'(rem_full)),
    .fit  (fit)
  );

  assign need     = {1'b0, s} + (TW+1)'(dur_q);
  assign rem_full = need - {1'b0, p};
  assign p_adv    = p + TW'(fit.span);
  assign a_adv    = a + AW'(fit.span);
  assign p_hit    = p + TW'(fit.f_off) + TW'(1);
  assign a_hit    = a + AW'(fit.f_off) + AW'(1);
  assign rdy_cur  = rdy_valid[rdy_addr_q] ? TW'(rdy_rdata) : '0;

  assign start_sat = (32'(s) > efr_pkg::SAT_MAX) ? 13'(efr_pkg::SAT_MAX) : 13'(s);
  assign end_sat   = (32'(need) > efr_pkg::SAT_MAX) ? 13'(efr_pkg::SAT_MAX) : 13'(need);
  assign le_new    = (!ovf_q && end_sat > latest_end) ? end_sat : latest_end;

  assign bad_req = (32'(job_id) >= JOBS) || (32'(machine_id) >= MACHINES) ||
                   (duration == '0) || (32'(duration) > MAX_DURATION);

  assign in_ready = (state == S_IDLE);
  assign post     = (state == S_FIN) && (!out_valid || out_ready);
  assign rdy_we   = post && !ovf_q;

  always_comb begin
    map_we    = (state == S_CLEAR) || (state == S_WMOD);
    map_waddr = (state == S_CLEAR) ? clr_cnt : word_of(a);
    map_wdata = (state == S_CLEAR) ? '0 : (map_rdata | fit.mask);
    case (state)
      S_EVAL, S_WMOD: map_raddr = word_of(a_adv);
      default:        map_raddr = word_of(a);
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      rdy_valid  <= '0;
      latest_end <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (post) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + MW'(1);
          if (clr_cnt == MW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            ovf_q <= bad_req;
            state <= bad_req ? S_FIN : S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (need > (TW+1)'(HORIZON)) begin
            ovf_q <= 1'b1;
            state <= S_FIN;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (fit.hit) begin
            state <= S_CHECK;
          end else if (fit.last) begin
            state <= S_WRD;
          end
        end
        S_WRD: begin
          state <= S_WMOD;
        end
        S_WMOD: begin
          if (fit.last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (post) begin
            if (!ovf_q) begin
              rdy_valid[rdy_addr_q] <= 1'b1;
              latest_end            <= le_new;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      mach_q     <= machine_id;
      dur_q      <= duration;
      rdy_addr_q <= JW'(job_id);
    end
    if (state == S_LOAD) begin
      s   <= rdy_cur;
      p   <= rdy_cur;
      a   <= AW'(32'(mach_q) * HORIZON) + AW'(rdy_cur);
      a_s <= AW'(32'(mach_q) * HORIZON) + AW'(rdy_cur);
    end
    if (state == S_EVAL) begin
      if (fit.hit) begin
        s   <= p_hit;
        p   <= p_hit;
        a   <= a_hit;
        a_s <= a_hit;
      end else if (fit.last) begin
        p <= s;
        a <= a_s;
      end else begin
        p <= p_adv;
        a <= a_adv;
      end
    end
    if (state == S_WMOD) begin
      p <= p_adv;
      a <= a_adv;
    end
    if (post) begin
      start_time <= ovf_q ? '0 : start_sat;
      end_time   <= ovf_q ? '0 : end_sat;
      makespan   <= le_new;
      overflow   <= ovf_q;
    end
  end

  a_scan_inside : assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL || state == S_WMOD) |-> ({1'b0, p} < need && p >= s))
    else $error("scan position left the candidate window");

  a_start_fits : assert property (@(posedge clk) disable iff (rst)
    (state == S_WRD) |-> (need <= (TW+1)'(HORIZON)))
    else $error("reservation runs past the horizon");

  a_result_order : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !overflow) |-> (end_time >= start_time && makespan >= end_time))
    else $error("start, end and makespan out of order");

  a_ovf_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (start_time == '0 && end_time == '0))
    else $error("rejected beat reports a slot");

  a_makespan_mono : assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !rst) |=> (latest_end >= $past(latest_end)))
    else $error("makespan decreased");

endmodule

// ===== hw/rtl/efr_ram.sv =====
module efr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/efr_word_unit.sv =====
module efr_word_unit (
  input  logic [efr_pkg::WORD_BITS-1:0] word,
  input  logic [efr_pkg::OFF_BITS-1:0]  off,
  input  logic [efr_pkg::LEN_BITS-1:0]  rem,
  output efr_pkg::fit_t                 fit
);

  logic [efr_pkg::LEN_BITS-1:0]  span;
  logic [efr_pkg::LEN_BITS-1:0]  len;
  logic                          last;
  logic [efr_pkg::WORD_BITS-1:0] low;
  logic [efr_pkg::WORD_BITS-1:0] mask;
  logic [efr_pkg::WORD_BITS-1:0] hits;
  logic [efr_pkg::OFF_BITS-1:0]  first;

  always_comb begin
    span = efr_pkg::LEN_BITS'(efr_pkg::WORD_BITS) - {1'b0, off};
    last = (rem <= span);
    len  = last ? rem : span;
    if (len == efr_pkg::LEN_BITS'(efr_pkg::WORD_BITS)) begin
      low = '1;
    end else begin
      low = (efr_pkg::WORD_BITS'(1) << len) - efr_pkg::WORD_BITS'(1);
    end
    mask = low << off;
    hits = word & mask;
    // lowest busy slot wins
    first = '0;
    for (int i = efr_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first = efr_pkg::OFF_BITS'(i);
      end
    end
  end

  assign fit.hit   = |hits;
  assign fit.last  = last;
  assign fit.f_off = first - off;
  assign fit.span  = span;
  assign fit.mask  = mask;

endmodule
